### rtl/core/evest_pkg.sv
// Shared types and constants for the encoder velocity estimator.
// Used by the register file, controller, datapath and top level.
package evest_pkg;

    localparam int COEF_REGS = 7;
    localparam logic [2:0] REG_ISP = 3'd7;
    localparam logic [23:0] ISP_RESET = 24'd1000;

    localparam logic [1:0] PH_FIRST = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_LATER = 2'd2;
    localparam logic [1:0] PH_SPARE = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL,
        OP_FIN_POS,
        OP_SET_DP,
        OP_FIN_T1,
        OP_FIN_VEL,
        OP_SET_B,
        OP_FIN_T2,
        OP_SUB_VEL,
        OP_SET_AC,
        OP_FIN_ACC,
        OP_FIX,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic hi;
    } cmd_t;

    typedef struct packed {
        logic axis_ok;
        logic filt;
    } stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_POS_LO,
        S_POS_HI,
        S_POS_FIN,
        S_VP_SET,
        S_VP_LO,
        S_VP_HI,
        S_VP_FIN,
        S_VB_SET,
        S_VB_LO,
        S_VB_HI,
        S_VB_FIN,
        S_VSUB,
        S_AC_SET,
        S_AC_LO,
        S_AC_HI,
        S_AC_FIN,
        S_FIX,
        S_DONE
    } state_t;

endpackage

### rtl/core/evest_cfg.sv
// Configuration register file: per-axis coefficient words and 1/T.
// Depends on evest_pkg.
module evest_cfg (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data,
    input  logic [2:0]  rd_axis,
    output logic [63:0] coef,
    output logic [23:0] isp
);
    import evest_pkg::*;

    logic [63:0] coef_reg [COEF_REGS];
    logic [23:0] isp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < COEF_REGS; i++)
            begin
                coef_reg[i] <= '0;
            end
            isp_reg <= ISP_RESET;
        end
        else if (wr_en)
        begin
            priority if (wr_index < 3'(COEF_REGS))
            begin
                coef_reg[wr_index] <= wr_data;
            end
            else if (wr_index == REG_ISP)
            begin
                isp_reg <= wr_data[23:0];
            end
        end
    end

    assign coef = (rd_axis < 3'(COEF_REGS)) ? coef_reg[rd_axis] : '0;
    assign isp  = isp_reg;

endmodule

### rtl/core/evest_ctrl.sv
// Sequencer for the estimator: steps the datapath through position,
// velocity and acceleration, owns the input stall and output valid.
// Depends on evest_pkg.
module evest_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    input  evest_pkg::stat_t stat,
    output evest_pkg::cmd_t  cmd
);
    import evest_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid && stat.axis_ok) state_next = S_POS_LO;
            S_POS_LO:  state_next = S_POS_HI;
            S_POS_HI:  state_next = S_POS_FIN;
            S_POS_FIN: state_next = S_VP_SET;
            S_VP_SET:  state_next = S_VP_LO;
            S_VP_LO:   state_next = S_VP_HI;
            S_VP_HI:   state_next = S_VP_FIN;
            S_VP_FIN:  state_next = stat.filt ? S_VB_SET : S_AC_SET;
            S_VB_SET:  state_next = S_VB_LO;
            S_VB_LO:   state_next = S_VB_HI;
            S_VB_HI:   state_next = S_VB_FIN;
            S_VB_FIN:  state_next = S_VSUB;
            S_VSUB:    state_next = S_AC_SET;
            S_AC_SET:  state_next = S_AC_LO;
            S_AC_LO:   state_next = S_AC_HI;
            S_AC_HI:   state_next = S_AC_FIN;
            S_AC_FIN:  state_next = S_FIX;
            S_FIX:     state_next = S_DONE;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op = OP_NONE;
        cmd.hi = 1'b0;
        unique case (state_reg)
            S_IDLE:    if (in_valid && stat.axis_ok) cmd.op = OP_LOAD;
            S_POS_LO, S_VP_LO, S_VB_LO, S_AC_LO:
                       cmd.op = OP_MUL;
            S_POS_HI, S_VP_HI, S_VB_HI, S_AC_HI:
            begin
                cmd.op = OP_MUL;
                cmd.hi = 1'b1;
            end
            S_POS_FIN: cmd.op = OP_FIN_POS;
            S_VP_SET:  cmd.op = OP_SET_DP;
            S_VP_FIN:  cmd.op = stat.filt ? OP_FIN_T1 : OP_FIN_VEL;
            S_VB_SET:  cmd.op = OP_SET_B;
            S_VB_FIN:  cmd.op = OP_FIN_T2;
            S_VSUB:    cmd.op = OP_SUB_VEL;
            S_AC_SET:  cmd.op = OP_SET_AC;
            S_AC_FIN:  cmd.op = OP_FIN_ACC;
            S_FIX:     cmd.op = OP_FIX;
            S_DONE:    if (out_free) cmd.op = OP_OUT;
            default:   cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        in_stall = (state_reg != S_IDLE);
        if (cmd.op == OP_OUT)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

    a_out_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |=> out_valid_reg)
        else $error("loaded item not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_OUT |-> (!out_valid_reg || !out_stall))
        else $error("output item overwritten while stalled");

    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && stat.axis_ok |=> state_reg == S_POS_LO)
        else $error("accepted item did not start");

    a_bad_axis_drop: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !stat.axis_ok |=> state_reg == S_IDLE)
        else $error("item for an unused axis started work");

endmodule

### rtl/core/evest_dp.sv
// Datapath: shared 25x24 multiplier with round/shift/saturate stage,
// one shared subtractor, per-axis old position and velocity.
// Depends on evest_pkg.
module evest_dp #(
    parameter int AXES = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  evest_pkg::cmd_t     cmd,
    output evest_pkg::stat_t    stat,
    input  logic [2:0]          axis,
    input  logic signed [31:0]  count,
    input  logic [1:0]          sample_phase,
    input  logic [63:0]         coef,
    input  logic [23:0]         isp,
    output logic [2:0]          out_axis,
    output logic signed [47:0]  position,
    output logic signed [47:0]  velocity,
    output logic signed [47:0]  acceleration
);
    import evest_pkg::*;

    localparam int LIVE = (AXES < COEF_REGS) ? AXES : COEF_REGS;
    localparam int AW   = (LIVE > 1) ? $clog2(LIVE) : 1;

    localparam logic signed [47:0] MAX48 = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MIN48 = 48'sh8000_0000_0000;

    typedef enum logic [1:0] {SH_L8, SH_R0, SH_R10, SH_R18} shift_t;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] r;
        if (v[48] != v[47])
            r = v[48] ? MIN48 : MAX48;
        else
            r = v[47:0];
        return r;
    endfunction

    logic signed [47:0] ppos_mem [LIVE];
    logic signed [47:0] pvel_mem [LIVE];

    logic [AW-1:0]      ax_reg;
    logic [1:0]         phase_reg;
    logic               filt_reg;
    logic               bneg_reg;
    logic [19:0]        bmag_reg;
    logic [21:0]        ga_reg;
    logic signed [47:0] oldp_reg, oldv_reg;
    logic signed [47:0] pos_reg, vel_reg, acc_reg, t1_reg, t2_reg;
    logic [49:0]        mag_reg;
    logic [23:0]        m_reg;
    logic               neg_reg;
    shift_t             sh_reg;
    logic [48:0]        pl_reg, ph_reg;
    logic [2:0]         oax_reg;
    logic signed [47:0] opos_reg, ovel_reg, oacc_reg;

    logic [AW-1:0]      in_idx;
    logic [31:0]        cmag;
    logic signed [19:0] braw;
    logic [24:0]        mfac;
    logic [48:0]        prod;
    logic [75:0]        rnd, sum;
    logic [83:0]        r;
    logic signed [47:0] fin_val;
    logic signed [47:0] da, db;
    logic signed [48:0] d;
    logic [48:0]        dneg;
    logic [49:0]        dmag;
    logic signed [47:0] vel_fix, acc_fix;

    assign in_idx = axis[AW-1:0];
    assign stat   = '{axis_ok: (axis < 3'(LIVE)), filt: filt_reg};

    assign cmag = count[31] ? (~count + 32'd1) : count;
    assign braw = coef[63:44];

    // multiplier: low half of the magnitude first, then the high half
    assign mfac = cmd.hi ? mag_reg[49:25] : mag_reg[24:0];
    assign prod = 49'(mfac) * 49'(m_reg);

    always_comb
    begin
        unique case (sh_reg)
            SH_R10:  rnd = 76'd1 << 9;
            SH_R18:  rnd = 76'd1 << 17;
            default: rnd = '0;
        endcase
        sum = (76'(ph_reg) << 25) + 76'(pl_reg) + rnd;
        unique case (sh_reg)
            SH_L8:   r = 84'(sum) << 8;
            SH_R0:   r = 84'(sum);
            SH_R10:  r = 84'(sum >> 10);
            SH_R18:  r = 84'(sum >> 18);
            default: r = 84'(sum);
        endcase
        if (neg_reg)
            fin_val = (r > 84'h8000_0000_0000) ? MIN48 : (~r[47:0] + 48'd1);
        else
            fin_val = (r > 84'h7FFF_FFFF_FFFF) ? MAX48 : r[47:0];
    end

    // shared subtractor
    always_comb
    begin
        unique case (cmd.op)
            OP_SET_DP:  begin da = pos_reg; db = oldp_reg; end
            OP_SET_B:   begin da = oldv_reg; db = '0; end
            OP_SUB_VEL: begin da = t1_reg;  db = t2_reg; end
            OP_SET_AC:  begin da = vel_reg; db = oldv_reg; end
            default:    begin da = '0;      db = '0; end
        endcase
        d    = {da[47], da} - {db[47], db};
        dneg = ~d + 49'd1;
        dmag = {1'b0, (d[48] ? dneg : d)};
    end

    // difference mode forces the early phases to zero
    always_comb
    begin
        vel_fix = vel_reg;
        acc_fix = acc_reg;
        if (!filt_reg)
        begin
            if (phase_reg == PH_FIRST)
            begin
                vel_fix = '0;
                acc_fix = '0;
            end
            else if (phase_reg == PH_SECOND)
            begin
                acc_fix = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LIVE; i++)
            begin
                ppos_mem[i] <= '0;
                pvel_mem[i] <= '0;
            end
        end
        else if (cmd.op == OP_FIX)
        begin
            ppos_mem[ax_reg] <= pos_reg;
            pvel_mem[ax_reg] <= vel_fix;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                ax_reg    <= in_idx;
                phase_reg <= sample_phase;
                filt_reg  <= coef[1];
                ga_reg    <= coef[43:22];
                bneg_reg  <= coef[63];
                bmag_reg  <= coef[63] ? (~braw + 20'd1) : braw;
                oldp_reg  <= (sample_phase == PH_FIRST) ? '0 : ppos_mem[in_idx];
                oldv_reg  <= (sample_phase == PH_FIRST) ? '0 : pvel_mem[in_idx];
                mag_reg   <= 50'(cmag);
                m_reg     <= 24'(coef[21:2]);
                neg_reg   <= count[31] ^ coef[0];
                sh_reg    <= SH_L8;
            end
            OP_MUL:
            begin
                if (cmd.hi)
                    ph_reg <= prod;
                else
                    pl_reg <= prod;
            end
            OP_FIN_POS: pos_reg <= fin_val;
            OP_FIN_T1:  t1_reg  <= fin_val;
            OP_FIN_T2:  t2_reg  <= fin_val;
            OP_FIN_VEL: vel_reg <= fin_val;
            OP_FIN_ACC: acc_reg <= fin_val;
            OP_SET_DP:
            begin
                mag_reg <= dmag;
                neg_reg <= d[48];
                m_reg   <= filt_reg ? 24'(ga_reg) : isp;
                sh_reg  <= filt_reg ? SH_R10 : SH_R0;
            end
            OP_SET_B:
            begin
                mag_reg <= dmag;
                neg_reg <= d[48] ^ bneg_reg;
                m_reg   <= 24'(bmag_reg);
                sh_reg  <= SH_R18;
            end
            OP_SUB_VEL: vel_reg <= sat48(d);
            OP_SET_AC:
            begin
                mag_reg <= dmag;
                neg_reg <= d[48];
                m_reg   <= isp;
                sh_reg  <= SH_R0;
            end
            OP_FIX:
            begin
                vel_reg <= vel_fix;
                acc_reg <= acc_fix;
            end
            OP_OUT:
            begin
                oax_reg  <= 3'(ax_reg);
                opos_reg <= pos_reg;
                ovel_reg <= vel_reg;
                oacc_reg <= acc_reg;
            end
            default: ;
        endcase
    end

    assign out_axis     = oax_reg;
    assign position     = opos_reg;
    assign velocity     = ovel_reg;
    assign acceleration = oacc_reg;

endmodule

### rtl/core/encoder_velocity_estimator.sv
// Encoder velocity estimator, top level: register file, sequencer, datapath.
// Depends on evest_pkg, evest_cfg, evest_ctrl, evest_dp.
//
// One encoder count per item; each item for a used axis yields one result
// (axis, position, velocity, acceleration, all Q16.32 saturated). Items for
// an axis at or above min(AXES, 7) are dropped without a result. Work is
// sequential on one item: the next item is accepted only once the
// current one has reached the output register and the sequencer is idle
// again; every product passes in two halves through the single shared
// 25x24 multiplier; filtering adds a product. A finished result waits
// in the output register while the next item is taken. Configuration
// writes are always ready and are meant for idle periods only.
module encoder_velocity_estimator #(
    parameter int AXES = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         axis,
    input  logic signed [31:0] count,
    input  logic [1:0]         sample_phase,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         out_axis,
    output logic signed [47:0] position,
    output logic signed [47:0] velocity,
    output logic signed [47:0] acceleration,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import evest_pkg::*;

    cmd_t        cmd;
    stat_t       stat;
    logic [63:0] coef;
    logic [23:0] isp;

    assign cfg_ready = 1'b1;

    evest_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .rd_axis  (axis),
        .coef     (coef),
        .isp      (isp)
    );

    evest_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    evest_dp #(
        .AXES (AXES)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .axis         (axis),
        .count        (count),
        .sample_phase (sample_phase),
        .coef         (coef),
        .isp          (isp),
        .out_axis     (out_axis),
        .position     (position),
        .velocity     (velocity),
        .acceleration (acceleration)
    );

endmodule
